// ----- sv/arp_lru_pkg.sv -----
// ----------------------------------------------------------------------------
// arp_lru_pkg
// Transaction types and codes shared by the address cache modules.
// ----------------------------------------------------------------------------
package arp_lru_pkg;

   localparam int KEY_W   = 32;
   localparam int MAC_W   = 48;
   localparam int STAMP_W = 32;
   localparam int INDEX_W = 3;

   localparam logic ACT_STORE  = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   typedef struct packed {
      logic             action;
      logic [KEY_W-1:0] ip_addr;
      logic [MAC_W-1:0] mac_addr;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [MAC_W-1:0]   mac_out;
      logic [INDEX_W-1:0] entry_index;
   } rsp_type;

endpackage

// ----- sv/arp_lru_match.sv -----
// ----------------------------------------------------------------------------
// arp_lru_match
// Parallel key compare over all entries, lowest valid match wins.
// ----------------------------------------------------------------------------
module arp_lru_match #(
   parameter int ENTRIES = 8,
   parameter int IW      = 3
) (
   input  logic [arp_lru_pkg::KEY_W-1:0] keys [ENTRIES],
   input  logic [ENTRIES-1:0]            valid,
   input  logic [arp_lru_pkg::KEY_W-1:0] key,
   output logic                          hit,
   output logic [IW-1:0]                 index
);

   logic [ENTRIES-1:0] match;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid[i] && (keys[i] == key);
      end
   end

   always_comb begin
      index = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            index = IW'(i);
         end
      end
      hit = |match;
   end

endmodule

// ----- sv/arp_lru_victim.sv -----
// ----------------------------------------------------------------------------
// arp_lru_victim
// Replacement choice: lowest free entry, else oldest stamp by comparator tree.
// ----------------------------------------------------------------------------
module arp_lru_victim #(
   parameter int ENTRIES = 8,
   parameter int IW      = 3
) (
   input  logic [ENTRIES-1:0]              valid,
   input  logic [arp_lru_pkg::STAMP_W-1:0] stamps [ENTRIES],
   output logic [IW-1:0]                   victim
);

   localparam int P   = 1 << IW;
   localparam int KW  = arp_lru_pkg::STAMP_W + 1;

   logic [KW-1:0] node_key [2*P];
   logic [IW-1:0] node_idx [2*P];
   logic [IW-1:0] free_idx;

   assign node_key[0] = '0;
   assign node_idx[0] = '0;

   // leaves, padding entries carry the top bit so they never win
   for (genvar l = 0; l < P; l++) begin : g_leaf
      if (l < ENTRIES) begin : g_real
         assign node_key[P+l] = {1'b0, stamps[l]};
      end else begin : g_pad
         assign node_key[P+l] = {1'b1, {arp_lru_pkg::STAMP_W{1'b0}}};
      end
      assign node_idx[P+l] = IW'(l);
   end

   // left side wins ties, giving the lowest index among equal stamps
   for (genvar n = 1; n < P; n++) begin : g_node
      logic right_wins;
      assign right_wins  = node_key[2*n+1] < node_key[2*n];
      assign node_key[n] = right_wins ? node_key[2*n+1] : node_key[2*n];
      assign node_idx[n] = right_wins ? node_idx[2*n+1] : node_idx[2*n];
   end

   always_comb begin
      free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid[i]) begin
            free_idx = IW'(i);
         end
      end
      victim = (&valid) ? node_idx[1] : free_idx;
   end

endmodule

// ----- sv/arp_cache_lru.sv -----
// ----------------------------------------------------------------------------
// arp_cache_lru
// Fully associative IPv4-to-MAC cache with oldest-stored replacement.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction: a store (action 0) of ip_addr/mac_addr or
//   a lookup (action 1) of ip_addr. rsp_* returns exactly one transaction
//   per request, in order: hit flag, MAC and entry number.
//   A request is captured in an input register; from there the key is
//   compared against all entries, the victim is chosen by a comparator tree
//   over the age stamps, the cache is updated and the response is loaded
//   into the output register. Throughput is one transaction per cycle, back
//   to back, while the receiver takes responses, since each request
//   finishes its cache update in the same cycle its response is
//   registered, so the next request always sees the updated entries.
//   When the receiver stalls, the response holds and the input register
//   keeps one more request; req_ready drops only while both are full.
//   Reset clears the valid bits, age stamps and age counter;
//   the block accepts requests in the cycle after reset.
// ----------------------------------------------------------------------------
module arp_cache_lru #(
   parameter int ENTRIES = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  arp_lru_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output arp_lru_pkg::rsp_type rsp_data
);

   localparam int IW = $clog2(ENTRIES);

   arp_lru_pkg::req_type               req_ff;
   logic                               req_valid_ff;
   logic                               req_valid_in;
   arp_lru_pkg::rsp_type               rsp_ff;
   arp_lru_pkg::rsp_type               rsp_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;

   logic [arp_lru_pkg::KEY_W-1:0]      key_ff   [ENTRIES];
   logic [arp_lru_pkg::MAC_W-1:0]      mac_ff   [ENTRIES];
   logic [arp_lru_pkg::STAMP_W-1:0]    stamp_ff [ENTRIES];
   logic [ENTRIES-1:0]                 valid_ff;
   logic [arp_lru_pkg::STAMP_W-1:0]    age_ff;
   logic [arp_lru_pkg::STAMP_W-1:0]    age_in;

   logic                               advance;
   logic                               match_hit;
   logic [IW-1:0]                      match_idx;
   logic [IW-1:0]                      victim_idx;
   logic                               wr_en;
   logic [IW-1:0]                      wr_slot;
   logic [IW+2:0]                      slot_ext;
   logic [IW+2:0]                      match_ext;

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   arp_lru_match #(
      .ENTRIES (ENTRIES),
      .IW      (IW)
   ) u_match (
      .keys  (key_ff),
      .valid (valid_ff),
      .key   (req_ff.ip_addr),
      .hit   (match_hit),
      .index (match_idx)
   );

   arp_lru_victim #(
      .ENTRIES (ENTRIES),
      .IW      (IW)
   ) u_victim (
      .valid  (valid_ff),
      .stamps (stamp_ff),
      .victim (victim_idx)
   );

   always_comb begin
      wr_en        = advance && (req_ff.action == arp_lru_pkg::ACT_STORE);
      wr_slot      = match_hit ? match_idx : victim_idx;
      slot_ext     = {3'b000, wr_slot};
      match_ext    = {3'b000, match_idx};
      age_in       = wr_en ? age_ff + 1'b1 : age_ff;
      req_valid_in = req_ready ? req_valid : req_valid_ff;
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
      rsp_in       = rsp_ff;
      if (advance) begin
         if (req_ff.action == arp_lru_pkg::ACT_LOOKUP) begin
            rsp_in.hit         = match_hit;
            rsp_in.mac_out     = match_hit ? mac_ff[match_idx] : '0;
            rsp_in.entry_index = match_hit ? match_ext[2:0] : '0;
         end else begin
            rsp_in.hit         = match_hit;
            rsp_in.mac_out     = req_ff.mac_addr;
            rsp_in.entry_index = slot_ext[2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         age_ff       <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            stamp_ff[i] <= '0;
         end
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         age_ff       <= age_in;
         if (wr_en) begin
            valid_ff[wr_slot] <= 1'b1;
            stamp_ff[wr_slot] <= age_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
      if (wr_en) begin
         mac_ff[wr_slot] <= req_ff.mac_addr;
         if (!match_hit) begin
            key_ff[wr_slot] <= req_ff.ip_addr;
         end
      end
   end

endmodule

// ----- sv/arp_lru_checker.sv -----
// ----------------------------------------------------------------------------
// arp_lru_checker
// Port-level checks for the address cache, bound to the top level.
// ----------------------------------------------------------------------------
module arp_lru_checker #(
   parameter int ENTRIES = 8
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input arp_lru_pkg::rsp_type rsp_data
);

   // empty after reset and ready for the first transaction
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not empty after reset");

   // a stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // input side blocks only behind a stalled response
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request blocked without output stall");

   // entry number stays inside the cache
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (ENTRIES >= 8) || (int'(rsp_data.entry_index) < ENTRIES))
      else $error("entry index out of range");

endmodule

bind arp_cache_lru arp_lru_checker #(
   .ENTRIES (ENTRIES)
) u_arp_lru_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- sim/tb_arp_cache_lru.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_arp_cache_lru
// Self-checking bench for the IPv4-to-MAC cache. A short list of corner
// rows (empty cache, all-zero and all-one keys and MACs, updates, fills and
// evictions) runs first. Random store/lookup traffic over small key pools
// follows, so that hits, updates and oldest-entry replacement all occur.
// A model predicts all but fixed-row responses. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_arp_cache_lru;

   localparam int ENTRIES     = 8;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 120;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 228;

   typedef struct packed {
      arp_lru_pkg::req_type  req;
      logic                  fixed;
      arp_lru_pkg::rsp_type  typed_rsp;
   } arp_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid;
   logic                 req_ready;
   arp_lru_pkg::req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   arp_lru_pkg::rsp_type rsp_data;

   // cache model
   logic [arp_lru_pkg::KEY_W-1:0]   cache_ip    [ENTRIES];
   logic [arp_lru_pkg::MAC_W-1:0]   cache_mac   [ENTRIES];
   logic                            cache_valid [ENTRIES];
   logic [arp_lru_pkg::STAMP_W-1:0] cache_stamp [ENTRIES];
   logic [arp_lru_pkg::STAMP_W-1:0] store_count;

   arp_lru_pkg::rsp_type pending_rsp [$];
   arp_row_type          directed_rows [$];
   logic [31:0]  key_pool [16];
   bit           tx_idle = 1'b1;
   bit           rx_idle = 1'b1;
   bit           hold_rx = 1'b0;
   int           err_count = 0;
   int           rsp_count = 0;
   int           req_count = 0;
   int           lookup_hits = 0;
   int           lookup_misses = 0;
   int           store_updates = 0;
   int           store_fills = 0;
   int           hold_count = 0;
   int           cycle_count = 0;

   arp_cache_lru #(
      .ENTRIES(ENTRIES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic arp_lru_pkg::rsp_type resolve_arp(input arp_lru_pkg::req_type r);
      arp_lru_pkg::rsp_type res;
      int                   entry;
      res   = '0;
      entry = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (entry < 0 && cache_valid[i] && cache_ip[i] == r.ip_addr)
            entry = i;
      if (r.action == arp_lru_pkg::ACT_LOOKUP) begin
         if (entry >= 0) begin
            res.hit         = 1'b1;
            res.mac_out     = cache_mac[entry];
            res.entry_index = entry[arp_lru_pkg::INDEX_W-1:0];
         end
         return res;
      end
      if (entry >= 0) begin
         res.hit = 1'b1;
      end else begin
         for (int i = 0; i < ENTRIES; i++)
            if (entry < 0 && !cache_valid[i])
               entry = i;
         if (entry < 0) begin
            entry = 0;
            for (int i = 1; i < ENTRIES; i++)
               if (cache_stamp[i] < cache_stamp[entry])
                  entry = i;
         end
         cache_ip[entry]    = r.ip_addr;
         cache_valid[entry] = 1'b1;
      end
      cache_mac[entry]   = r.mac_addr;
      store_count        = store_count + 1'b1;
      cache_stamp[entry] = store_count;
      res.mac_out        = r.mac_addr;
      res.entry_index    = entry[arp_lru_pkg::INDEX_W-1:0];
      return res;
   endfunction

   function automatic void add_row(input logic act,
                                   input logic [arp_lru_pkg::KEY_W-1:0] ip,
                                   input logic [arp_lru_pkg::MAC_W-1:0] mac,
                                   input logic fixed,
                                   input logic hit,
                                   input logic [arp_lru_pkg::MAC_W-1:0] mac_out,
                                   input logic [arp_lru_pkg::INDEX_W-1:0] idx);
      arp_row_type row;
      row.req.action          = act;
      row.req.ip_addr         = ip;
      row.req.mac_addr        = mac;
      row.fixed               = fixed;
      row.typed_rsp.hit       = hit;
      row.typed_rsp.mac_out   = mac_out;
      row.typed_rsp.entry_index = idx;
      directed_rows.push_back(row);
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic arp_lru_pkg::req_type random_req(input int pool_n);
      arp_lru_pkg::req_type r;
      int                   pick;
      logic [63:0]          wide;
      r.action = ($urandom_range(0, 1) == 0) ? arp_lru_pkg::ACT_STORE
                                              : arp_lru_pkg::ACT_LOOKUP;
      pick = $urandom_range(0, 99);
      if (pick < 85)
         r.ip_addr = key_pool[$urandom_range(0, pool_n - 1)];
      else if (pick < 95)
         r.ip_addr = $urandom;
      else
         r.ip_addr = pick[0] ? '1 : '0;
      pick = $urandom_range(0, 19);
      wide = {$urandom, $urandom};
      if (pick == 0)
         r.mac_addr = '0;
      else if (pick == 1)
         r.mac_addr = '1;
      else
         r.mac_addr = wide[arp_lru_pkg::MAC_W-1:0];
      return r;
   endfunction

   task automatic issue_req(input arp_lru_pkg::req_type r, input logic fixed,
                            input arp_lru_pkg::rsp_type typed_rsp);
      arp_lru_pkg::rsp_type predicted;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predicted = resolve_arp(r);
      pending_rsp.push_back(fixed ? typed_rsp : predicted);
      req_count++;
      if (r.action == arp_lru_pkg::ACT_LOOKUP) begin
         if (predicted.hit)
            lookup_hits++;
         else
            lookup_misses++;
      end else if (predicted.hit) begin
         store_updates++;
      end else begin
         store_fills++;
      end
   endtask

   task automatic idle_tx(input int n);
      if (n > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // receiver: random ready pattern plus the long hold-off on request
   initial begin
      int run;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rx) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_count++;
            hold_rx = 1'b0;
         end else if (rx_idle && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            run = pick_gap();
            repeat ((run > 0) ? run : 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      arp_lru_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response transaction with nothing pending: %h", rsp_data);
            err_count++;
         end else begin
            want = pending_rsp.pop_front();
            rsp_count++;
            if (rsp_data.hit !== want.hit) begin
               $error("hit: expected %b, got %b", want.hit, rsp_data.hit);
               err_count++;
            end
            if (rsp_data.mac_out !== want.mac_out) begin
               $error("mac_out: expected %h, got %h", want.mac_out, rsp_data.mac_out);
               err_count++;
            end
            if (rsp_data.entry_index !== want.entry_index) begin
               $error("entry_index: expected %0d, got %0d", want.entry_index,
                      rsp_data.entry_index);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending", cycle_count,
                  pending_rsp.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int pool_sizes [PHASES];
      pool_sizes = '{3, 8, 9, 12, 16, 8, 5, 16};
      req_valid = 1'b0;
      req_data  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         cache_ip[i]    = '0;
         cache_mac[i]   = '0;
         cache_valid[i] = 1'b0;
         cache_stamp[i] = '0;
      end
      store_count = '0;

      // empty cache, all-zero and all-one keys and MACs
      add_row(arp_lru_pkg::ACT_LOOKUP, 32'h0000_0000, 48'h0000_0000_0000,
              1'b1, 1'b0, 48'h0, 3'd0);
      add_row(arp_lru_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
              1'b1, 1'b0, 48'h0, 3'd0);
      add_row(arp_lru_pkg::ACT_STORE,  32'h0000_0000, 48'h0000_0000_0000,
              1'b1, 1'b0, 48'h0, 3'd0);
      add_row(arp_lru_pkg::ACT_STORE,  32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
              1'b1, 1'b0, 48'hFFFF_FFFF_FFFF, 3'd1);
      add_row(arp_lru_pkg::ACT_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF,
              1'b1, 1'b1, 48'h0, 3'd0);
      add_row(arp_lru_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000,
              1'b1, 1'b1, 48'hFFFF_FFFF_FFFF, 3'd1);
      // update in place
      add_row(arp_lru_pkg::ACT_STORE,  32'hFFFF_FFFF, 48'h1234_5678_9ABC,
              1'b1, 1'b1, 48'h1234_5678_9ABC, 3'd1);
      add_row(arp_lru_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
              1'b1, 1'b1, 48'h1234_5678_9ABC, 3'd1);
      add_row(arp_lru_pkg::ACT_LOOKUP, 32'h1234_5678, 48'hA5A5_A5A5_A5A5,
              1'b1, 1'b0, 48'h0, 3'd0);
      // fill the free entries in order
      add_row(arp_lru_pkg::ACT_STORE,  32'hC0A8_0102, 48'h0200_0000_0002,
              1'b1, 1'b0, 48'h0200_0000_0002, 3'd2);
      add_row(arp_lru_pkg::ACT_STORE,  32'hC0A8_0103, 48'h0200_0000_0003,
              1'b1, 1'b0, 48'h0200_0000_0003, 3'd3);
      add_row(arp_lru_pkg::ACT_STORE,  32'hC0A8_0104, 48'h0200_0000_0004,
              1'b1, 1'b0, 48'h0200_0000_0004, 3'd4);
      add_row(arp_lru_pkg::ACT_STORE,  32'hC0A8_0105, 48'h0200_0000_0005,
              1'b1, 1'b0, 48'h0200_0000_0005, 3'd5);
      add_row(arp_lru_pkg::ACT_STORE,  32'hC0A8_0106, 48'h0200_0000_0006,
              1'b1, 1'b0, 48'h0200_0000_0006, 3'd6);
      add_row(arp_lru_pkg::ACT_STORE,  32'hC0A8_0107, 48'h0200_0000_0007,
              1'b1, 1'b0, 48'h0200_0000_0007, 3'd7);
      // full cache: oldest-stored replacement
      add_row(arp_lru_pkg::ACT_STORE,  32'h0A00_0001, 48'hAAAA_5555_0001,
              1'b0, 1'b0, 48'h0, 3'd0);
      add_row(arp_lru_pkg::ACT_LOOKUP, 32'h0000_0000, 48'h0000_0000_0000,
              1'b0, 1'b0, 48'h0, 3'd0);
      add_row(arp_lru_pkg::ACT_STORE,  32'h0A00_0002, 48'hAAAA_5555_0002,
              1'b0, 1'b0, 48'h0, 3'd0);
      add_row(arp_lru_pkg::ACT_STORE,  32'hC0A8_0102, 48'h5555_AAAA_0102,
              1'b0, 1'b0, 48'h0, 3'd0);
      add_row(arp_lru_pkg::ACT_STORE,  32'h0A00_0003, 48'hAAAA_5555_0003,
              1'b0, 1'b0, 48'h0, 3'd0);
      add_row(arp_lru_pkg::ACT_LOOKUP, 32'hC0A8_0102, 48'h0000_0000_0000,
              1'b0, 1'b0, 48'h0, 3'd0);
      add_row(arp_lru_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000,
              1'b0, 1'b0, 48'h0, 3'd0);
      add_row(arp_lru_pkg::ACT_STORE,  32'h0A00_0001, 48'hFFFF_0000_FFFF,
              1'b0, 1'b0, 48'h0, 3'd0);

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         issue_req(directed_rows[k].req, directed_rows[k].fixed, directed_rows[k].typed_rsp);
         idle_tx(pick_gap());
      end
      idle_tx(1);
      while (pending_rsp.size() != 0)
         @(posedge clock);

      for (int ph = 0; ph < PHASES; ph++) begin
         tx_idle = (ph != 2 && ph != 5);
         rx_idle = tx_idle;
         foreach (key_pool[k])
            key_pool[k] = $urandom;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ((ph == 3 || ph == 6) && n == 40)
               hold_rx = 1'b1;
            issue_req(random_req(pool_sizes[ph]), 1'b0, '0);
            idle_tx((hold_rx || !tx_idle) ? 0 : pick_gap());
         end
         idle_tx(1);
         while (pending_rsp.size() != 0)
            @(posedge clock);
      end

      repeat (8) @(posedge clock);
      $display("%0d requests, %0d responses checked, %0d long receiver hold-offs",
               req_count, rsp_count, hold_count);
      $display("lookups: %0d hit, %0d miss; stores: %0d updates, %0d fills or evictions",
               lookup_hits, lookup_misses, store_updates, store_fills);
      if (err_count == 0 && pending_rsp.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
